### hdl/ogrid_pkg.sv
// ----------------------------------------------------------------------------
// ogrid_pkg: shared types and constants of the occupancy grid hit update
// Beat layouts, register indexes, quarter-sine coefficients and the
// fixed-point truncation helpers used by the datapath.
// ----------------------------------------------------------------------------
package ogrid_pkg;

	localparam int GRID_COLS_MAX  = 256;
	localparam int GRID_ROWS_MAX  = 256;
	localparam int ANGLE_BITS     = 16;
	localparam int DIST_FRAC_BITS = 8;

	localparam int MEM_DEPTH = GRID_COLS_MAX * GRID_ROWS_MAX;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	// angle scaled onto a 32-bit turn
	localparam logic [31:0] ANGLE_MASK  = 32'((64'd1 << ANGLE_BITS) - 64'd1);
	localparam int          ANGLE_SHIFT = 32 - ANGLE_BITS;

	// coordinate = (origin * 2^SHIFT + trig * dist) / 2^SHIFT
	localparam int COORD_SHIFT = 30 + DIST_FRAC_BITS;
	localparam int SUM_W       = 48 + DIST_FRAC_BITS;
	localparam int COORD_W     = SUM_W - COORD_SHIFT;

	localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

	// register indexes on the configuration port
	localparam int            CFG_IDX_W     = 2;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd1;

	// odd polynomial for sin(pi/2 * t), Q30, Horner in t^2
	localparam logic signed [31:0] SIN_COEF [7] = '{
		32'sd1686629713, -32'sd693598668, 32'sd85569305, -32'sd5026995,
		32'sd172272, -32'sd3864, 32'sd61
	};

	typedef struct packed {
		logic [7:0]  origin_x;
		logic [7:0]  origin_y;
		logic [15:0] ray_angle;
		logic [15:0] ray_dist;
		logic        ray_hit;
	} ray_beat_t;

	typedef struct packed {
		logic [7:0] cell_x;
		logic [7:0] cell_y;
		logic       updated;
		logic [1:0] cell_level;
	} cell_beat_t;

	// product / 2^30, truncated toward zero
	function automatic logic signed [31:0] q30_trunc(input logic signed [63:0] p);
		logic [33:0] hi;
		hi = p[63:30] + 34'(p[63] && (p[29:0] != 30'd0));
		return hi[31:0];
	endfunction

	// (origin * 2^COORD_SHIFT + prod) / 2^COORD_SHIFT, truncated toward zero
	function automatic logic [COORD_W-1:0] coord_trunc(input logic [7:0] origin,
			input logic signed [63:0] prod);
		logic [SUM_W-1:0] sum;
		logic             round_up;
		sum = (SUM_W'(origin) << COORD_SHIFT) + prod[SUM_W-1:0];
		round_up = sum[SUM_W-1] && (sum[COORD_SHIFT-1:0] != '0);
		return sum[SUM_W-1:COORD_SHIFT] + COORD_W'(round_up);
	endfunction

endpackage

### hdl/occupancy_grid_ray_hit_update.sv
// ----------------------------------------------------------------------------
// occupancy_grid_ray_hit_update: range hit to occupancy grid cell update
// Range readings come in on a valid/ready channel. Each hit is turned into a
// grid cell through a polynomial sine/cosine; the cell's 2-bit hit count is
// bumped (saturating at 3) and reported on the result channel.
//  - Input beat (in_data): origin, binary angle, Q8.8 distance, hit flag.
//    Result beat (out_data): cell, updated flag and new level, one per input.
//  - One 32x32 signed multiplier with a product register; each product is
//    used in the state after the one that launched it. A hit runs the two
//    quarter sines (square, six Horner steps, final scale), the x/y offsets,
//    a bounds check, a read-modify-write (skipped when the cell is off the
//    grid) and the output load; a reading without a hit skips to the load.
//  - in_ready is high only while the sequencer is idle; the next reading is
//    taken the cycle after a result is loaded, not while one is in flight.
//  - Results sit in an output register: a stalled receiver does not block
//    the next accept, only the hand-off of the next result.
//  - After reset the grid store is swept to zero, one cell a cycle; in_ready
//    stays low meanwhile. grid_cols / grid_rows reset to 256 and should only
//    be written while the block is idle.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_hit_update
	import ogrid_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [8:0]           cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ray_beat_t            in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cell_beat_t           out_data
);

	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_UMUL  = 4'd1;   // arg * arg
	localparam logic [3:0] ST_UDIV  = 4'd2;   // u = arg^2 / 2^30
	localparam logic [3:0] ST_HMUL  = 4'd3;   // acc * u
	localparam logic [3:0] ST_HADD  = 4'd4;   // acc = coef[k] + prod / 2^30
	localparam logic [3:0] ST_TMUL  = 4'd5;   // acc * arg
	localparam logic [3:0] ST_TDIV  = 4'd6;   // quarter sine done
	localparam logic [3:0] ST_XMUL  = 4'd7;   // cos * dist
	localparam logic [3:0] ST_XSUM  = 4'd8;   // x from product, launch sin * dist
	localparam logic [3:0] ST_YSUM  = 4'd9;   // y from product
	localparam logic [3:0] ST_CHECK = 4'd10;  // bounds check, grid read
	localparam logic [3:0] ST_RMW   = 4'd11;  // increment and write back
	localparam logic [3:0] ST_DONE  = 4'd12;  // hand result to output register

	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MEM_DEPTH - 1);

	// control state
	logic [3:0]        state_q;
	logic              clr_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              out_valid_q;
	logic [8:0]        grid_cols_q;
	logic [8:0]        grid_rows_q;

	// datapath registers
	logic [7:0]         ox_q, oy_q;
	logic [15:0]        dist_q;
	logic [1:0]         quad_q;
	logic               phase_q;      // 0: sin(t), 1: sin(1 - t)
	logic [2:0]         k_q;
	logic signed [31:0] t_q, tc_q, u_q, acc_q, sv_q, cv_q;
	logic signed [63:0] prod_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic [1:0]         rd_q;
	cell_beat_t         res_q;
	cell_beat_t         out_data_q;

	// grid store
	logic [1:0] grid_mem [MEM_DEPTH];

	logic               in_fire;
	logic               res_load;
	logic signed [31:0] arg;
	logic signed [31:0] sin_v, cos_v;
	logic signed [31:0] mul_a, mul_b;
	logic signed [31:0] horner_v;
	logic signed [31:0] qsine_v;
	logic [31:0]        angle32;
	logic [COORD_W-1:0] cols_eff, rows_eff;
	logic               in_grid;
	logic [ADDR_W-1:0]  cell_addr;
	logic [1:0]         lvl_next;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [1:0]         mem_wdata;

	assign in_ready  = (state_q == ST_IDLE) && !clr_q;
	assign in_fire   = in_valid && in_ready;
	assign res_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign angle32 = (32'(in_data.ray_angle) & ANGLE_MASK) << ANGLE_SHIFT;
	assign arg     = phase_q ? tc_q : t_q;

	// quadrant folding
	always_comb begin
		case (quad_q)
			2'd0: begin
				sin_v = sv_q;
				cos_v = cv_q;
			end
			2'd1: begin
				sin_v = cv_q;
				cos_v = -sv_q;
			end
			2'd2: begin
				sin_v = -sv_q;
				cos_v = -cv_q;
			end
			default: begin
				sin_v = -cv_q;
				cos_v = sv_q;
			end
		endcase
	end

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			ST_UMUL: begin
				mul_a = arg;
				mul_b = arg;
			end
			ST_HMUL: begin
				mul_a = acc_q;
				mul_b = u_q;
			end
			ST_TMUL: begin
				mul_a = acc_q;
				mul_b = arg;
			end
			ST_XMUL: begin
				mul_a = cos_v;
				mul_b = 32'(dist_q);
			end
			ST_XSUM: begin
				mul_a = sin_v;
				mul_b = 32'(dist_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign horner_v = SIN_COEF[k_q] + q30_trunc(prod_q);
	assign qsine_v  = q30_trunc(prod_q);

	// bounds against the clamped grid size
	assign cols_eff = (grid_cols_q > 9'(GRID_COLS_MAX)) ? COORD_W'(GRID_COLS_MAX)
		: COORD_W'(grid_cols_q);
	assign rows_eff = (grid_rows_q > 9'(GRID_ROWS_MAX)) ? COORD_W'(GRID_ROWS_MAX)
		: COORD_W'(grid_rows_q);
	assign in_grid = !x_q[COORD_W-1] && !y_q[COORD_W-1]
		&& (x_q < cols_eff) && (y_q < rows_eff);
	assign cell_addr = ADDR_W'(y_q) * ADDR_W'(GRID_COLS_MAX) + ADDR_W'(x_q);
	assign lvl_next  = (rd_q == 2'd3) ? 2'd3 : rd_q + 2'd1;

	// one write port: clearing sweep or the update
	assign mem_we    = clr_q || (state_q == ST_RMW);
	assign mem_waddr = clr_q ? clr_cnt_q : cell_addr;
	assign mem_wdata = clr_q ? 2'd0 : lvl_next;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= grid_mem[cell_addr];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			grid_cols_q <= 9'd256;
			grid_rows_q <= 9'd256;
			phase_q     <= 1'b0;
			k_q         <= '0;
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					REG_GRID_COLS: grid_cols_q <= cfg_wdata;
					REG_GRID_ROWS: grid_rows_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == CLR_LAST) begin
					clr_q <= 1'b0;
				end
			end

			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						phase_q <= 1'b0;
						state_q <= in_data.ray_hit ? ST_UMUL : ST_DONE;
					end
				end
				ST_UMUL: state_q <= ST_UDIV;
				ST_UDIV: begin
					k_q     <= 3'd5;
					state_q <= ST_HMUL;
				end
				ST_HMUL: state_q <= ST_HADD;
				ST_HADD: begin
					if (k_q == 3'd0) begin
						state_q <= ST_TMUL;
					end else begin
						k_q     <= k_q - 3'd1;
						state_q <= ST_HMUL;
					end
				end
				ST_TMUL: state_q <= ST_TDIV;
				ST_TDIV: begin
					phase_q <= 1'b1;
					state_q <= phase_q ? ST_XMUL : ST_UMUL;
				end
				ST_XMUL:  state_q <= ST_XSUM;
				ST_XSUM:  state_q <= ST_YSUM;
				ST_YSUM:  state_q <= ST_CHECK;
				ST_CHECK: state_q <= in_grid ? ST_RMW : ST_DONE;
				ST_RMW:   state_q <= ST_DONE;
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_UMUL, ST_HMUL, ST_TMUL, ST_XMUL, ST_XSUM: prod_q <= mul_a * mul_b;
			default: ;
		endcase

		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					ox_q   <= in_data.origin_x;
					oy_q   <= in_data.origin_y;
					dist_q <= in_data.ray_dist;
					quad_q <= angle32[31:30];
					t_q    <= 32'(angle32[29:0]);
					tc_q   <= Q30_ONE - 32'(angle32[29:0]);
					res_q  <= '0;
				end
			end
			ST_UDIV: begin
				u_q   <= qsine_v;
				acc_q <= SIN_COEF[6];
			end
			ST_HADD: acc_q <= horner_v;
			ST_TDIV: begin
				if (phase_q) begin
					cv_q <= qsine_v;
				end else begin
					sv_q <= qsine_v;
				end
			end
			ST_XSUM: x_q <= coord_trunc(ox_q, prod_q);
			ST_YSUM: y_q <= coord_trunc(oy_q, prod_q);
			ST_CHECK: begin
				if (!in_grid) begin
					res_q <= '0;
				end
			end
			ST_RMW: begin
				res_q.cell_x     <= x_q[7:0];
				res_q.cell_y     <= y_q[7:0];
				res_q.updated    <= 1'b1;
				res_q.cell_level <= lvl_next;
			end
			default: ;
		endcase

		if (res_load) begin
			out_data_q <= res_q;
		end
	end

endmodule

### sim/occupancy_grid_ray_hit_update_checker.sv
// ----------------------------------------------------------------------------
// occupancy_grid_ray_hit_update_checker: hit-cell predictor and result checker
// Watches the config port and both beat channels, keeps its own copy of the
// grid counts and register values, and predicts one result beat per reading.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_hit_update_checker
	import ogrid_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [8:0]           cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  ray_beat_t            in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  cell_beat_t           out_data,
	output int                   fail_count,
	output int                   outstanding,
	output int                   checked
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ONE_Q30     = 64'sd1073741824;
	localparam longint COORD_SCALE = 64'sd1 << 38;	// Q30 trig times Q8.8 distance
	localparam int     MAP_SIDE    = 256;

	// sin(pi/2 * t) as an odd polynomial, Q30, lowest order first
	localparam longint SINE_TERMS [7] = '{
		64'sd1686629713, -64'sd693598668, 64'sd85569305, -64'sd5026995,
		64'sd172272, -64'sd3864, 64'sd61
	};

	typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quadrant_t;

	logic [1:0]  hits [MAP_SIDE*MAP_SIDE];
	logic [8:0]  grid_cols = 9'd256;
	logic [8:0]  grid_rows = 9'd256;
	cell_beat_t  cells_due [$];
	cell_beat_t  due;
	int          fails     = 0;
	int          n_checked = 0;

	function automatic longint quarter_sine(longint t);
		longint u;
		longint acc;
		u   = (t * t) / ONE_Q30;
		acc = SINE_TERMS[6];
		for (int k = 5; k >= 0; k--)
			acc = SINE_TERMS[k] + (acc * u) / ONE_Q30;
		return (acc * t) / ONE_Q30;
	endfunction

	// predicted result of one reading; bumps the mirrored cell count
	function automatic cell_beat_t hit_cell(ray_beat_t r);
		logic [31:0] turn;
		quadrant_t   quad;
		longint      t, s_part, c_part, sn, cs, x, y, cols, rows;
		int          cell_idx;
		logic [1:0]  lvl;
		cell_beat_t  res;
		res = '0;
		if (!r.ray_hit)
			return res;
		turn   = {r.ray_angle, 16'h0000};
		quad   = quadrant_t'(turn[31:30]);
		t      = {34'd0, turn[29:0]};
		s_part = quarter_sine(t);
		c_part = quarter_sine(ONE_Q30 - t);
		case (quad)
			QUAD_I: begin
				sn = s_part;
				cs = c_part;
			end
			QUAD_II: begin
				sn = c_part;
				cs = -s_part;
			end
			QUAD_III: begin
				sn = -s_part;
				cs = -c_part;
			end
			default: begin
				sn = -c_part;
				cs = s_part;
			end
		endcase
		// signed division truncates toward zero, so (-1,0) lands on 0
		x = (longint'(r.origin_x) * COORD_SCALE + cs * longint'(r.ray_dist)) / COORD_SCALE;
		y = (longint'(r.origin_y) * COORD_SCALE + sn * longint'(r.ray_dist)) / COORD_SCALE;
		cols = (grid_cols > MAP_SIDE) ? MAP_SIDE : longint'(grid_cols);
		rows = (grid_rows > MAP_SIDE) ? MAP_SIDE : longint'(grid_rows);
		if (x < 0 || x >= cols || y < 0 || y >= rows)
			return res;
		cell_idx = int'(y) * MAP_SIDE + int'(x);
		lvl      = hits[cell_idx];
		if (lvl != 2'd3)
			lvl = lvl + 2'd1;
		hits[cell_idx] = lvl;
		res.cell_x     = x[7:0];
		res.cell_y     = y[7:0];
		res.updated    = 1'b1;
		res.cell_level = lvl;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (hits[i])
				hits[i] = 2'd0;
			grid_cols = 9'd256;
			grid_rows = 9'd256;
			cells_due.delete();
			fails       = 0;
			n_checked   = 0;
			fail_count  <= 0;
			outstanding <= 0;
			checked     <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					REG_GRID_COLS: grid_cols = cfg_wdata;
					REG_GRID_ROWS: grid_rows = cfg_wdata;
					default: ;
				endcase
			end
			// results leave in order, so the oldest prediction is the match
			if (out_valid && out_ready) begin
				if (cells_due.size() == 0) begin
					$error("result beat with no reading pending: %p", out_data);
					fails++;
				end else begin
					due = cells_due.pop_front();
					n_checked++;
					if (out_data.cell_x !== due.cell_x) begin
						$error("cell_x: expected %0d, got %0d", due.cell_x, out_data.cell_x);
						fails++;
					end
					if (out_data.cell_y !== due.cell_y) begin
						$error("cell_y: expected %0d, got %0d", due.cell_y, out_data.cell_y);
						fails++;
					end
					if (out_data.updated !== due.updated) begin
						$error("updated: expected %0d, got %0d", due.updated, out_data.updated);
						fails++;
					end
					if (out_data.cell_level !== due.cell_level) begin
						$error("cell_level: expected %0d, got %0d", due.cell_level,
							out_data.cell_level);
						fails++;
					end
				end
			end
			if (in_valid && in_ready)
				cells_due = {cells_due, hit_cell(in_data)};
			fail_count  <= fails;
			outstanding <= cells_due.size();
			checked     <= n_checked;
		end
	end

endmodule

### sim/occupancy_grid_ray_hit_update_tb.sv
// ----------------------------------------------------------------------------
// occupancy_grid_ray_hit_update_tb: testbench top for the grid hit update
// Drives range readings and grid size settings into the block, with random
// idle bursts on both channels; the checker beside it predicts every result.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_hit_update_tb
	import ogrid_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_PHASES      = 12;
	localparam int BEATS_A_PHASE = 150;
	localparam int SETTLE_CYCLES = 8;	// result is registered; lets the sequencer go idle
	localparam int TAIL_CYCLES   = 60;
	// clear sweep plus ~1850 readings, many times over
	localparam int CYCLE_LIMIT   = 1_500_000;

	// indexes past the last register; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// fixed grid sizes for the first phases: empty, oversized, single row/col
	localparam int PHASE_COLS [8] = '{1, 0, 511, 256, 257, 17, 256, 2};
	localparam int PHASE_ROWS [8] = '{1, 256, 511, 0, 3, 200, 1, 256};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx   = REG_GRID_COLS;
	logic [8:0]           cfg_wdata = 9'd0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	ray_beat_t            in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	cell_beat_t           out_data;

	int fail_count;
	int outstanding;
	int checked;

	logic calm       = 1'b0;	// no idling on either side once set
	int   stall_left = 0;
	int   cycles     = 0;
	int   n_sent     = 0;
	int   n_settings = 1;

	occupancy_grid_ray_hit_update i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	occupancy_grid_ray_hit_update_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.checked     (checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("occupancy_grid_ray_hit_update_tb failed");
			$finish;
		end
	end

	// receiver: random stall bursts, none in the calm tail
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 11) - 1;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic ray_beat_t ray(input logic [7:0] ox, input logic [7:0] oy,
			input logic [15:0] angle, input logic [15:0] reach, input logic hit);
		ray_beat_t r;
		r.origin_x  = ox;
		r.origin_y  = oy;
		r.ray_angle = angle;
		r.ray_dist  = reach;
		r.ray_hit   = hit;
		return r;
	endfunction

	// mix of reading shapes: wide sweeps, clustered near the corner (fraction
	// truncation, negative coordinates, saturation), near-axis angles, short rays
	function automatic ray_beat_t random_ray();
		ray_beat_t r;
		r.ray_hit   = ($urandom_range(0, 9) != 0);
		r.origin_x  = 8'($urandom);
		r.origin_y  = 8'($urandom);
		r.ray_angle = 16'($urandom);
		r.ray_dist  = 16'($urandom);
		case ($urandom_range(0, 3))
			0: ;
			1: begin
				r.origin_x = 8'($urandom_range(0, 7));
				r.origin_y = 8'($urandom_range(0, 7));
				r.ray_dist = 16'($urandom_range(0, 16'h0300));
			end
			2: begin
				r.ray_angle = {2'($urandom), 14'd0} + 16'($urandom_range(0, 4)) - 16'd2;
				r.ray_dist  = 16'($urandom_range(0, 16'h4000));
			end
			default: r.ray_dist = 16'($urandom_range(0, 16'h1000));
		endcase
		return r;
	endfunction

	// one reading; an optional idle burst first, then hold until accepted
	task automatic send_ray(input ray_beat_t r);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	// every result home, then a settle wait for the sequencer
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both size registers, then a write to an unused index
	task automatic set_grid(input logic [8:0] cols, input logic [8:0] rows);
		cfg_wen   <= 1'b1;
		cfg_idx   <= REG_GRID_COLS;
		cfg_wdata <= cols;
		@(posedge clk);
		cfg_idx   <= REG_GRID_ROWS;
		cfg_wdata <= rows;
		@(posedge clk);
		cfg_idx   <= ($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B;
		cfg_wdata <= 9'($urandom);
		@(posedge clk);
		cfg_wen <= 1'b0;
		n_settings++;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset grid size 256 x 256
		send_ray(ray(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 1'b0));	// no hit, fields high
		send_ray(ray(8'd0, 8'd0, 16'h0000, 16'h0000, 1'b0));	// no hit, fields low
		repeat (4)
			send_ray(ray(8'd0, 8'd0, 16'h0000, 16'h0000, 1'b1));	// climbs to 3 and sticks
		send_ray(ray(8'd255, 8'd255, 16'h0000, 16'h0000, 1'b1));	// far corner
		send_ray(ray(8'd255, 8'd0, 16'h0000, 16'h0100, 1'b1));	// one cell past right edge
		send_ray(ray(8'd0, 8'd5, 16'h8000, 16'h0080, 1'b1));	// x = -0.5 truncates to 0
		send_ray(ray(8'd0, 8'd5, 16'h8000, 16'h0200, 1'b1));	// x negative
		send_ray(ray(8'd5, 8'd0, 16'hC000, 16'hFFFF, 1'b1));	// y negative
		send_ray(ray(8'd0, 8'd0, 16'h4000, 16'hFFFF, 1'b1));	// straight up, max distance
		send_ray(ray(8'd0, 8'd0, 16'h0000, 16'hFFFF, 1'b1));	// straight right, max distance
		send_ray(ray(8'd128, 8'd128, 16'h2000, 16'h2000, 1'b1));	// one per quadrant
		send_ray(ray(8'd128, 8'd128, 16'h6000, 16'h2000, 1'b1));
		send_ray(ray(8'd128, 8'd128, 16'hA000, 16'h2000, 1'b1));
		send_ray(ray(8'd128, 8'd128, 16'hE000, 16'h2000, 1'b1));
		send_ray(ray(8'd128, 8'd128, 16'hFFFF, 16'h1000, 1'b1));	// last angle step
		send_ray(ray(8'd200, 8'd3, 16'h8001, 16'hFFFF, 1'b1));	// far past left edge

		// random phases, each under its own grid size
		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			if (p < 8)
				set_grid(9'(PHASE_COLS[p]), 9'(PHASE_ROWS[p]));
			else if (p < N_PHASES - 1)
				set_grid(9'($urandom_range(1, 511)), 9'($urandom_range(1, 300)));
			else begin
				set_grid(9'd256, 9'd256);
				calm <= 1'b1;
			end
			repeat (BEATS_A_PHASE)
				send_ray(random_ray());
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d range readings under %0d grid size settings", n_sent, n_settings);
		$display("checked %0d result beats, %0d mismatches", checked, fail_count);
		if (fail_count == 0 && outstanding == 0)
			$display("occupancy_grid_ray_hit_update_tb passed");
		else
			$display("occupancy_grid_ray_hit_update_tb failed");
		$finish;
	end

endmodule
